FILE: design/tpaf_pkg.sv
// ----------------------------------------------------------------------------
// tpaf_pkg
// Shared widths, reset values and the entry update function of the two-way
// page access filter.
// ----------------------------------------------------------------------------
package tpaf_pkg;

	localparam int ADDR_W     = 36;
	localparam int PAGE_LSB   = 12;
	localparam int PAGE_W     = 24;
	localparam int CNT_W      = 7;
	localparam int ENTRY_W    = PAGE_W + 1 + CNT_W;
	localparam int ROW_W      = 2 * ENTRY_W;
	localparam int SETS_DEF   = 8192;
	localparam logic [CNT_W-1:0] THR_RESET = 7'd8;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             hit;
		logic             way;
		logic [CNT_W-1:0] count;
		logic             hot;
	} upd_t;

	// Entry layout: tag in the top bits, then the recently-used mark, then the count.
	// Way 0 sits in the low half of a row, way 1 in the high half.
	function automatic upd_t update(input logic [ROW_W-1:0] row,
	                                input logic [PAGE_W-1:0] page,
	                                input logic [CNT_W-1:0] thr);
		logic [ENTRY_W-1:0] e0;
		logic [ENTRY_W-1:0] e1;
		logic [ENTRY_W-1:0] sel;
		logic [ENTRY_W-1:0] other;
		logic               hit0;
		logic               hit1;
		logic [CNT_W-1:0]   old_cnt;
		upd_t               r;
		e0   = row[ENTRY_W-1:0];
		e1   = row[ROW_W-1:ENTRY_W];
		hit0 = (e0[ENTRY_W-1 -: PAGE_W] == page);
		hit1 = (e1[ENTRY_W-1 -: PAGE_W] == page);
		r.hit = hit0 | hit1;
		// On a miss the victim is way 1 exactly when way 1 is not marked recently used.
		r.way = hit0 ? 1'b0 : (hit1 ? 1'b1 : ~e1[CNT_W]);
		sel   = r.way ? e1 : e0;
		other = r.way ? e0 : e1;
		old_cnt = sel[CNT_W-1:0];
		if (r.hit) begin
			r.hot   = (old_cnt >= thr);
			r.count = r.hot ? old_cnt : CNT_W'(old_cnt + 1'b1);
		end else begin
			r.hot   = 1'b0;
			r.count = CNT_W'(1);
		end
		sel   = {page, 1'b1, r.count};
		other[CNT_W] = 1'b0;
		r.row = r.way ? {sel, other} : {other, sel};
		return r;
	endfunction

endpackage

FILE: design/tpaf_set_index.sv
// ----------------------------------------------------------------------------
// tpaf_set_index
// Reduces a page number to its set index (page modulo SETS). A power-of-two
// set count is a mask; any other count uses a reciprocal multiply pipeline.
// ----------------------------------------------------------------------------
module tpaf_set_index #(
	parameter int SETS  = tpaf_pkg::SETS_DEF,
	parameter int IDX_W = $clog2(SETS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tpaf_pkg::PAGE_W-1:0] page,
	output logic                        done,
	output logic [IDX_W-1:0]            idx
);

	localparam int PW = tpaf_pkg::PAGE_W;
	localparam bit POW2 = ((SETS & (SETS - 1)) == 0);

	generate
		if (POW2) begin : g_mask
			logic             done_q;
			logic [IDX_W-1:0] idx_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					idx_q <= page[IDX_W-1:0];
				end
			end

			assign done = done_q;
			assign idx  = idx_q;
		end else begin : g_recip
			// Quotient by rounded-up reciprocal; exact for every 24-bit page.
			localparam longint unsigned NUM     = 64'd1 << (PW + IDX_W);
			localparam longint unsigned RECIP_L = (NUM + SETS - 1) / SETS;
			localparam logic [PW:0]     RECIP   = (PW + 1)'(RECIP_L);

			logic [2*PW:0]      prod;
			logic [PW+IDX_W:0]  qd_full;
			logic               valid_s1;
			logic               valid_s2;
			logic               done_q;
			logic [PW-1:0]      q_s1;
			logic [PW-1:0]      page_s1;
			logic [PW-1:0]      qd_s2;
			logic [PW-1:0]      page_s2;
			logic [IDX_W-1:0]   idx_q;

			assign prod    = (2*PW + 1)'(page) * (2*PW + 1)'(RECIP);
			assign qd_full = (PW + IDX_W + 1)'(q_s1) * (PW + IDX_W + 1)'(SETS);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s1 <= 1'b0;
					valid_s2 <= 1'b0;
					done_q   <= 1'b0;
				end else begin
					valid_s1 <= start;
					valid_s2 <= valid_s1;
					done_q   <= valid_s2;
				end
			end

			always_ff @(posedge clk) begin
				q_s1    <= PW'(prod >> (PW + IDX_W));
				page_s1 <= page;
				qd_s2   <= PW'(qd_full);
				page_s2 <= page_s1;
				idx_q   <= IDX_W'(page_s2 - qd_s2);
			end

			assign done = done_q;
			assign idx  = idx_q;
		end
	endgenerate

endmodule

FILE: design/tpaf_table.sv
// ----------------------------------------------------------------------------
// tpaf_table
// Set memory: one row per set holding both ways, registered read,
// and a clearing sweep after reset that zeroes one row per cycle.
// ----------------------------------------------------------------------------
module tpaf_table #(
	parameter int SETS  = tpaf_pkg::SETS_DEF,
	parameter int IDX_W = $clog2(SETS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [IDX_W-1:0]           rd_idx,
	output logic [tpaf_pkg::ROW_W-1:0] rd_data,
	input  logic                       wr_en,
	input  logic [IDX_W-1:0]           wr_idx,
	input  logic [tpaf_pkg::ROW_W-1:0] wr_data,
	output logic                       ready
);

	logic [tpaf_pkg::ROW_W-1:0] mem [SETS];
	logic [tpaf_pkg::ROW_W-1:0] rd_data_q;
	logic [IDX_W-1:0]           clr_idx_q;
	logic                       clr_busy_q;
	logic                       we;
	logic [IDX_W-1:0]           wa;
	logic [tpaf_pkg::ROW_W-1:0] wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_idx_q <= IDX_W'(clr_idx_q + 1'b1);
			if (clr_idx_q == IDX_W'(SETS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign we = clr_busy_q | wr_en;
	assign wa = clr_busy_q ? clr_idx_q : wr_idx;
	assign wd = clr_busy_q ? '0 : wr_data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;
	assign ready   = ~clr_busy_q;

endmodule

FILE: design/two_way_page_access_filter.sv
// ----------------------------------------------------------------------------
// two_way_page_access_filter
// Two-way set-associative hot page filter over a physical address stream.
// ----------------------------------------------------------------------------
// One item is in flight at a time. Each item passes through the set index,
// memory read and memory write-back before the next is accepted; a SETS that
// is not a power of two forms the set index by a reciprocal multiply pipeline
// instead of a mask. The result waits in an output register, and the
// write-back of an item stalls only while that register is still full.
// After reset the table memory is cleared one set per cycle, and no word is
// accepted until the clearing ends; hot_threshold may be written meanwhile.
// ----------------------------------------------------------------------------
module two_way_page_access_filter #(
	parameter int SETS = tpaf_pkg::SETS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// cfg_data: hot_threshold[6:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	// s_tdata: phys_addr[35:0], zero padding [39:36]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	// m_tdata: hit[0], way_used[1], access_count[8:2], hot[9], zero padding [15:10]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata
);

	localparam int IDX_W = $clog2(SETS);
	localparam int PW    = tpaf_pkg::PAGE_W;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_INDEX  = 4'b0010,
		ST_READ   = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t                          state_q;
	logic [tpaf_pkg::CNT_W-1:0]      thr_q;
	logic [PW-1:0]                   page_q;
	logic [IDX_W-1:0]                idx_q;
	logic                            out_valid_q;
	logic [15:0]                     out_data_q;
	logic                            in_fire;
	logic                            idx_done;
	logic [IDX_W-1:0]                idx;
	logic [tpaf_pkg::ROW_W-1:0]      rd_data;
	logic                            tbl_ready;
	logic                            rd_en;
	logic                            wr_en;
	tpaf_pkg::upd_t                  upd;

	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid & s_tready;
	assign s_tready  = (state_q == ST_IDLE) & tbl_ready;
	assign rd_en     = (state_q == ST_INDEX) & idx_done;
	assign wr_en     = (state_q == ST_UPDATE) & (~out_valid_q | m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tpaf_pkg::THR_RESET;
		end else if (cfg_valid & cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	tpaf_set_index #(.SETS(SETS), .IDX_W(IDX_W)) u_set_index (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.page   (s_tdata[tpaf_pkg::PAGE_LSB +: PW]),
		.done   (idx_done),
		.idx    (idx)
	);

	tpaf_table #(.SETS(SETS), .IDX_W(IDX_W)) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_idx  (idx),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_idx  (idx_q),
		.wr_data (upd.row),
		.ready   (tbl_ready)
	);

	assign upd = tpaf_pkg::update(rd_data, page_q, thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_INDEX;
					end
				end
				ST_INDEX: begin
					if (idx_done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (wr_en) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (wr_en) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			page_q <= s_tdata[tpaf_pkg::PAGE_LSB +: PW];
		end
		if (rd_en) begin
			idx_q <= idx;
		end
		if (wr_en) begin
			out_data_q <= {6'd0, upd.hot, upd.count, upd.way, upd.hit};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// No word may enter while the table is still being cleared.
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!tbl_ready |-> !in_fire)
		else $error("input word accepted during table clearing");

	// The sequencer is always in exactly one state.
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	// A miss installs a fresh entry with count one and is never hot.
	a_miss_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[8:2] == 7'd1 && !m_tdata[9]))
		else $error("miss result with wrong count or hot flag");

	// After a memory read the sequencer goes through the read state to the update state.
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> ##1 (state_q == ST_UPDATE))
		else $error("update state not reached after memory read");

endmodule
